// ----- hw/rtl/lfsa_pkg.sv -----
// lfsa_pkg: shared types and constants for the lowest free slot allocator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lfsa_pkg;

   localparam int MAX_SLOTS_DEFAULT = 64;

   // field widths of the channels
   localparam int CMD_W       = 2;
   localparam int TAG_W       = 32;
   localparam int SLOT_IN_W   = 32;
   localparam int SLOT_OUT_W  = 6;
   localparam int STATUS_W    = 1;
   localparam int CAPACITY_W  = 7;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - TAG_W - SLOT_OUT_W;

   localparam int CAPACITY_RESET = 64;

   // search groups of the busy map
   localparam int GROUP_SLOTS = 32;
   localparam int GROUP_IDX_W = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;

   localparam logic [STATUS_W-1:0] STATUS_SUCCESS = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_FAILURE = 1'b1;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_BAD   = 2'd2
   } kind_type;

   // classified item as it travels from front to back
   typedef struct packed {
      kind_type         kind;
      logic [TAG_W-1:0] tag;
      logic             slot_hi_zero;
   } cmd_meta_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lowest_free_slot_allocator.sv -----
// Lowest free slot allocator: one busy bit per slot, first-fit allocate.
// Top level; depends on lfsa_pkg, lfsa_front, lfsa_queue and lfsa_back.
// A front stage takes one request item per cycle into a two-entry queue unless it is
// full. The back end retires frees, and unsupported commands when the reply register is
// free; an allocate registers the lowest free slot per 32-slot group, then picks the
// lowest group and loads the reply register once free. A reply waits there while new
// items are accepted. Writing csr_wr_data sets the pool size and frees every slot; sizes
// above MAX_SLOTS count as MAX_SLOTS, and a size of zero makes every allocate fail.
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_slot_allocator import lfsa_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // task_tag, free_slot
   input  wire logic [CMD_W-1:0]       req_tuser,  // command
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // reply_tag, granted_slot, zero pad
   output logic [STATUS_W-1:0]         rsp_tuser,  // status
   input  wire logic                   csr_wr_en,
   input  wire logic [CAPACITY_W-1:0]  csr_wr_data
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   logic              q_push, q_full, q_valid, q_pop;
   cmd_meta_type      wr_meta, rd_meta;
   logic [SLOT_W-1:0] wr_slot, rd_slot;
   logic [TAG_W-1:0]  rsp_tag;
   logic [SLOT_OUT_W-1:0] rsp_slot;

   lfsa_front #(.SLOT_W(SLOT_W)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_meta     (wr_meta),
      .q_slot     (wr_slot)
   );

   lfsa_queue #(.SLOT_W(SLOT_W)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_meta  (wr_meta),
      .wr_slot  (wr_slot),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_en    (q_pop),
      .rd_meta  (rd_meta),
      .rd_slot  (rd_slot)
   );

   lfsa_back #(.MAX_SLOTS(MAX_SLOTS), .SLOT_W(SLOT_W)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_meta      (rd_meta),
      .q_slot      (rd_slot),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tag     (rsp_tag),
      .rsp_status  (rsp_tuser),
      .rsp_slot    (rsp_slot)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_slot, rsp_tag};

endmodule

`default_nettype wire

// ----- hw/rtl/lfsa_front.sv -----
// lfsa_front: accepts request items and classifies them for the back end.
// Depends on lfsa_pkg; feeds lfsa_queue.
`timescale 1ns / 1ps
`default_nettype none

module lfsa_front import lfsa_pkg::*; #(
   parameter int SLOT_W = 6
) (
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // task_tag, free_slot
   input  wire logic [CMD_W-1:0]       req_tuser,  // command
   input  wire logic                   q_full,
   output logic                        q_push,
   output cmd_meta_type                q_meta,
   output logic [SLOT_W-1:0]           q_slot
);

   logic [TAG_W-1:0]     tag;
   logic [SLOT_IN_W-1:0] free_slot;

   assign tag       = req_tdata[TAG_W-1:0];
   assign free_slot = req_tdata[TAG_W +: SLOT_IN_W];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_meta.tag = tag;
      // a slot above the index range can never be in the pool
      q_meta.slot_hi_zero = (free_slot[SLOT_IN_W-1:SLOT_W] == '0);
      unique case (req_tuser)
         CMD_ALLOCATE: q_meta.kind = KIND_ALLOC;
         CMD_FREE:     q_meta.kind = KIND_FREE;
         default:      q_meta.kind = KIND_BAD;
      endcase
   end

   assign q_slot = free_slot[SLOT_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/lfsa_queue.sv -----
// lfsa_queue: two-entry queue between the front and back of the allocator.
// Depends on lfsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfsa_queue import lfsa_pkg::*; #(
   parameter int SLOT_W = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire cmd_meta_type      wr_meta,
   input  wire logic [SLOT_W-1:0] wr_slot,
   output logic                   full,
   output logic                   rd_valid,
   input  wire logic              rd_en,
   output cmd_meta_type           rd_meta,
   output logic [SLOT_W-1:0]      rd_slot
);

   cmd_meta_type            meta_ff [QUEUE_DEPTH];
   logic [SLOT_W-1:0]       slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_wr, do_rd;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   assign rd_meta = meta_ff[rd_ptr_ff];
   assign rd_slot = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         meta_ff[wr_ptr_ff] <= wr_meta;
         slot_ff[wr_ptr_ff] <= wr_slot;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lfsa_back.sv -----
// lfsa_back: busy map, pool size register, lowest free slot search and reply register.
// Depends on lfsa_pkg; drains lfsa_queue.
`timescale 1ns / 1ps
`default_nettype none

module lfsa_back import lfsa_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT,
   parameter int SLOT_W    = 6
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   output logic                        q_pop,
   input  wire cmd_meta_type           q_meta,
   input  wire logic [SLOT_W-1:0]      q_slot,
   input  wire logic                   csr_wr_en,
   input  wire logic [CAPACITY_W-1:0]  csr_wr_data,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [TAG_W-1:0]            rsp_tag,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [SLOT_OUT_W-1:0]       rsp_slot
);

   localparam int LIMIT_W     = $clog2(MAX_SLOTS + 1);
   localparam int LIMIT_RESET = (CAPACITY_RESET > MAX_SLOTS) ? MAX_SLOTS : CAPACITY_RESET;
   localparam int NUM_GROUPS  = (MAX_SLOTS + GROUP_SLOTS - 1) / GROUP_SLOTS;
   localparam int AVAIL_W     = NUM_GROUPS * GROUP_SLOTS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PICK = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [MAX_SLOTS-1:0]    busy_ff, busy_in;
   logic [LIMIT_W-1:0]      limit_ff, limit_in;
   logic [TAG_W-1:0]        cur_tag_ff, cur_tag_in;

   logic [NUM_GROUPS-1:0]   grp_any_ff, grp_any_in;
   logic [GROUP_IDX_W-1:0]  grp_idx_ff [NUM_GROUPS];
   logic [GROUP_IDX_W-1:0]  grp_idx_in [NUM_GROUPS];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]        rsp_tag_ff, rsp_tag_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic [AVAIL_W-1:0]      avail;
   logic                    pick_any;
   logic [SLOT_W-1:0]       pick_slot;
   logic [31:0]             pick_wide;
   logic                    out_free;
   logic                    free_hit;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign free_hit = q_meta.slot_hi_zero && (32'(q_slot) < 32'(limit_ff));

   // free slots that lie inside the pool in use
   always_comb begin
      avail = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         avail[i] = !busy_ff[i] && (32'(i) < 32'(limit_ff));
      end
   end

   // first level: lowest free slot within each group, registered
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g] = |avail[g*GROUP_SLOTS +: GROUP_SLOTS];
         grp_idx_in[g] = '0;
         for (int b = GROUP_SLOTS - 1; b >= 0; b--) begin
            if (avail[g*GROUP_SLOTS + b]) begin
               grp_idx_in[g] = GROUP_IDX_W'(b);
            end
         end
      end
   end

   // second level: lowest group that has a free slot
   always_comb begin
      pick_any  = 1'b0;
      pick_wide = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick_any  = 1'b1;
            pick_wide = 32'(g) * 32'(GROUP_SLOTS) + 32'(grp_idx_ff[g]);
         end
      end
      pick_slot = pick_wide[SLOT_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      limit_in      = limit_ff;
      cur_tag_in    = cur_tag_ff;
      q_pop         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_meta.kind)
                  KIND_FREE: begin
                     q_pop = 1'b1;
                     if (free_hit) begin
                        busy_in[q_slot] = 1'b0;
                     end
                  end
                  KIND_ALLOC: begin
                     // group summaries are captured at this edge
                     q_pop      = 1'b1;
                     cur_tag_in = q_meta.tag;
                     state_in   = ST_PICK;
                  end
                  default: begin
                     if (out_free) begin
                        q_pop         = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_tag_in    = q_meta.tag;
                        rsp_status_in = STATUS_FAILURE;
                        rsp_slot_in   = '0;
                     end
                  end
               endcase
            end
         end
         ST_PICK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = cur_tag_ff;
               if (pick_any) begin
                  busy_in[pick_slot] = 1'b1;
                  rsp_status_in      = STATUS_SUCCESS;
                  rsp_slot_in        = pick_wide[SLOT_OUT_W-1:0];
               end else begin
                  rsp_status_in = STATUS_FAILURE;
                  rsp_slot_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // new pool size frees every slot
      if (csr_wr_en) begin
         busy_in  = '0;
         limit_in = (32'(csr_wr_data) > 32'(MAX_SLOTS)) ? LIMIT_W'(MAX_SLOTS)
                                                        : LIMIT_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         limit_ff     <= LIMIT_W'(LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_tag_ff    <= cur_tag_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      grp_any_ff    <= grp_any_in;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tag    = rsp_tag_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   a_csr_clears_map: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> busy_ff == '0)
      else $error("busy map not cleared after pool size write");

   a_grant_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK && out_free && pick_any)
      |=> (busy_ff[$past(pick_slot)] || $past(csr_wr_en)))
      else $error("granted slot not marked busy");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FAILURE) |-> rsp_slot_ff == '0)
      else $error("failure reply carries a nonzero slot");

endmodule

`default_nettype wire

// ----- bench/slot_grant_checker.sv -----
// slot_grant_checker: watches the request, reply and csr channels of the slot allocator,
// keeps its own busy map and pool size, and compares every reply with the predicted one.
// Depends on lfsa_pkg for field widths and command and status codes.
`timescale 1ns / 1ps

module slot_grant_checker import lfsa_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // task_tag, free_slot
   input  wire logic [CMD_W-1:0]       req_tuser,   // command
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,   // reply_tag, granted_slot, zero pad
   input  wire logic [STATUS_W-1:0]    rsp_tuser,   // status
   input  wire logic                   csr_wr_en,
   input  wire logic [CAPACITY_W-1:0]  csr_wr_data,
   output int                          failures,
   output int                          pending,
   output int                          grants,
   output int                          refusals
);

   typedef struct packed {
      logic [TAG_W-1:0]      tag;
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
   } reply_type;

   reply_type                    expected_replies[$];
   logic [MAX_SLOTS_DEFAULT-1:0] busy_map;
   logic [CAPACITY_W-1:0]        capacity;

   initial begin
      failures = 0;
      pending  = 0;
      grants   = 0;
      refusals = 0;
   end

   // applies one request to the busy map; returns 1 when a reply is due
   function automatic bit serve_request(input logic [CMD_W-1:0] cmd,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [SLOT_IN_W-1:0] slot,
                                        output reply_type reply);
      int limit;
      limit = (capacity > MAX_SLOTS_DEFAULT) ? MAX_SLOTS_DEFAULT : int'(capacity);
      reply.tag    = tag;
      reply.status = STATUS_FAILURE;
      reply.slot   = '0;
      if (cmd == CMD_FREE) begin
         // slots not busy or outside the pool are simply ignored
         if (slot < limit) begin
            busy_map[slot] = 1'b0;
         end
         return 1'b0;
      end
      if (cmd == CMD_ALLOCATE) begin
         for (int i = 0; i < limit; i++) begin
            if (!busy_map[i]) begin
               busy_map[i]  = 1'b1;
               reply.status = STATUS_SUCCESS;
               reply.slot   = SLOT_OUT_W'(i);
               break;
            end
         end
      end
      return 1'b1;
   endfunction

   task automatic compare_field(input string what, input logic [TAG_W-1:0] want,
                                input logic [TAG_W-1:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         capacity = CAPACITY_W'(CAPACITY_RESET);
         busy_map = '0;
         expected_replies.delete();
      end else begin
         if (csr_wr_en) begin
            capacity = csr_wr_data;
            busy_map = '0;
         end
         // replies first: a reply never belongs to an item accepted on the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.tag    = rsp_tdata[TAG_W-1:0];
            got.status = rsp_tuser;
            got.slot   = rsp_tdata[TAG_W +: SLOT_OUT_W];
            if (expected_replies.size() == 0) begin
               failures++;
               $display("%0t: reply with none expected, got tag %0h status %0h slot %0d",
                        $time, got.tag, got.status, got.slot);
            end else begin
               want = expected_replies.pop_front();
               compare_field("reply_tag", want.tag, got.tag);
               compare_field("status", TAG_W'(want.status), TAG_W'(got.status));
               compare_field("granted_slot", TAG_W'(want.slot), TAG_W'(got.slot));
               if (want.status == STATUS_SUCCESS) begin
                  grants++;
               end else begin
                  refusals++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (serve_request(req_tuser, req_tdata[TAG_W-1:0],
                              req_tdata[TAG_W +: SLOT_IN_W], want)) begin
               expected_replies.push_back(want);
            end
         end
      end
      pending = expected_replies.size();
   end

endmodule

// ----- bench/tb_lowest_free_slot_allocator.sv -----
// tb_lowest_free_slot_allocator: drives request items and pool size writes into the
// slot allocator and gives the verdict; checking is done by slot_grant_checker.
// Depends on lfsa_pkg, slot_grant_checker and lowest_free_slot_allocator.
`timescale 1ns / 1ps

module tb_lowest_free_slot_allocator;
   import lfsa_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNSUPPORTED_A = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNSUPPORTED_B = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // task_tag, free_slot
   logic [CMD_W-1:0]       req_tuser = '0;   // command
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // reply_tag, granted_slot, zero pad
   logic [STATUS_W-1:0]    rsp_tuser;        // status
   logic                   csr_wr_en = 1'b0;
   logic [CAPACITY_W-1:0]  csr_wr_data = '0;

   int failures;
   int pending;
   int grants;
   int refusals;
   int items_sent = 0;
   int settings_used = 1;
   int current_limit = MAX_SLOTS_DEFAULT;
   bit steady = 1'b0;

   always #5 clock = ~clock;

   lowest_free_slot_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   slot_grant_checker grant_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending),
      .grants      (grants),
      .refusals    (refusals)
   );

   // reply side back-pressure
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 34);
   end

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                               input logic [SLOT_IN_W-1:0] slot);
      if (!steady && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {slot, tag};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic drain_replies(input int tail);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   // frees take no reply, so leave room for the last of them before writing
   task automatic set_capacity(input logic [CAPACITY_W-1:0] size);
      drain_replies(20);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      current_limit = (size > MAX_SLOTS_DEFAULT) ? MAX_SLOTS_DEFAULT : int'(size);
      settings_used++;
   endtask

   task automatic run_random_phase(input logic [CAPACITY_W-1:0] size, input int count,
                                   input int alloc_pct, input bit no_gaps);
      int pick;
      set_capacity(size);
      steady = no_gaps;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct) begin
            send_request(CMD_ALLOCATE, $urandom, $urandom);
         end else if (pick < alloc_pct + (100 - alloc_pct) * 7 / 10) begin
            send_request(CMD_FREE, $urandom,
                         (current_limit == 0) ? 0 : $urandom_range(0, current_limit - 1));
         end else if (pick < 92 + alloc_pct / 20) begin
            send_request(CMD_FREE, $urandom, $urandom);
         end else if (pick < 96) begin
            send_request(CMD_FREE, $urandom, current_limit);
         end else begin
            send_request(($urandom_range(0, 1) != 0) ? CMD_UNSUPPORTED_A : CMD_UNSUPPORTED_B,
                         $urandom, $urandom);
         end
         // now and then hold off until the block has answered everything
         if ($urandom_range(0, 39) == 0) begin
            drain_replies(0);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full pool after reset: lowest-first grants, reuse, ignored frees, bad commands
      send_request(CMD_ALLOCATE, 32'h0000_0000, 32'h0);
      send_request(CMD_ALLOCATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_ALLOCATE, 32'hA5A5_5A5A, 32'h0);
      send_request(CMD_FREE, 32'h1234_5678, 32'd1);
      send_request(CMD_ALLOCATE, 32'h5A5A_A5A5, 32'h0);
      send_request(CMD_FREE, 32'h0, 32'd1);
      send_request(CMD_FREE, 32'h0, 32'd1);
      send_request(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_FREE, 32'h0, 32'd64);
      send_request(CMD_FREE, 32'h0, 32'd63);
      send_request(CMD_UNSUPPORTED_A, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
      send_request(CMD_UNSUPPORTED_B, 32'h8000_0001, 32'd0);

      // single slot: exhaustion and release
      set_capacity(7'd1);
      send_request(CMD_ALLOCATE, 32'h0000_0011, 32'h0);
      send_request(CMD_ALLOCATE, 32'h0000_0012, 32'h0);
      send_request(CMD_FREE, 32'h0, 32'd0);
      send_request(CMD_ALLOCATE, 32'h0000_0013, 32'h0);
      send_request(CMD_FREE, 32'h0, 32'd1);

      // empty pool: every allocate fails
      set_capacity(7'd0);
      send_request(CMD_ALLOCATE, 32'h0000_0021, 32'h0);
      send_request(CMD_FREE, 32'h0, 32'd0);
      send_request(CMD_UNSUPPORTED_B, 32'h0000_0022, 32'h0);

      run_random_phase(7'd127, 90, 85, 1'b0);
      run_random_phase(7'd3, 40, 55, 1'b0);
      run_random_phase(7'd64, 70, 60, 1'b1);
      run_random_phase(7'd1, 30, 50, 1'b0);
      run_random_phase(7'd0, 15, 50, 1'b0);
      run_random_phase(7'd40, 60, 60, 1'b0);
      run_random_phase(CAPACITY_W'($urandom_range(2, 63)), 60, 55, 1'b0);
      run_random_phase(7'd100, 60, 65, 1'b0);

      drain_replies(20);
      $display("covered %0d request items over %0d pool sizes, including 0, 1, 64 and 127",
               items_sent, settings_used);
      $display("%0d slot grants and %0d failure replies compared", grants, refusals);
      if (failures == 0) begin
         $display("lowest_free_slot_allocator: match");
      end else begin
         $display("lowest_free_slot_allocator: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("lowest_free_slot_allocator: mismatch");
      $finish;
   end

endmodule
